// File: hw/rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, constants and character helpers for the s-expression scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package sts_pkg;

  localparam int MAX_WORD   = 32;
  localparam int WLEN_W     = $clog2(MAX_WORD + 1);
  localparam int NKW        = 13;
  localparam int KW_POS     = 5;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] MAG_CAP    = 32'h8000_0000;
  localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;
  localparam logic [31:0] ERR_SIGNED = 32'd1;
  localparam logic [31:0] ERR_LONG   = 32'd2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_CASE   = 8'h20;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2,
    MODE_UNK  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    KIND_NAME     = 4'd0,
    KIND_NUMBER   = 4'd1,
    KIND_LPAREN   = 4'd2,
    KIND_RPAREN   = 4'd3,
    KIND_QUOTE    = 4'd4,
    KIND_KEYWORD  = 4'd5,
    KIND_VARIABLE = 4'd6,
    KIND_UNKNOWN  = 4'd7,
    KIND_END      = 4'd8,
    KIND_ERROR    = 4'd9
  } kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    mode_t             mode;
    logic [31:0]       acc;    // magnitude, capped at MAG_CAP
    logic              neg;
    logic [1:0]        swf;    // [0] signed word, [1] junk after digits
    logic [NKW-1:0]    kwm;
    logic [WLEN_W-1:0] wlen;
    logic [7:0]        first;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    mode:  MODE_IDLE,
    acc:   '0,
    neg:   1'b0,
    swf:   '0,
    kwm:   '1,
    wlen:  '0,
    first: '0
  };

  typedef struct packed {
    logic [1:0]           count;
    out_item_t [1:0]      item;
  } step_out_t;

  typedef struct packed {
    logic                  room2;
    logic [FIFO_CNT_W-1:0] level;
  } fifo_status_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_PLUS || c == CH_MINUS ||
           c == CH_STAR || c == CH_SLASH || c == CH_EQ || c == CH_LT ||
           c == CH_GT || c == CH_UNDER || c == CH_HASH;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - CH_CASE : c;
  endfunction

  // acc * 10 + digit, saturating at MAG_CAP
  function automatic logic [31:0] accumulate(input logic [31:0] acc, input logic [7:0] c);
    logic [35:0] v;
    v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, c[3:0]};
    return (v > {4'd0, MAG_CAP}) ? MAG_CAP : v[31:0];
  endfunction

  function automatic logic [2:0] kw_len(input int k);
    logic [2:0] len;
    unique case (k)
      0, 1, 2, 3:     len = 3'd1;
      5, 8, 9:        len = 3'd3;
      6, 7:           len = 3'd4;
      4, 10, 11, 12:  len = 3'd5;
      default:        len = 3'd0;
    endcase
    return len;
  endfunction

  // keyword text, first character in the top byte, zero padded
  function automatic logic [8*KW_POS-1:0] kw_word(input int k);
    logic [8*KW_POS-1:0] w;
    unique case (k)
      0:       w = {CH_PLUS,  32'd0};
      1:       w = {CH_MINUS, 32'd0};
      2:       w = {CH_STAR,  32'd0};
      3:       w = {CH_SLASH, 32'd0};
      4:       w = "QUOTE";
      5:       w = {"SET", 16'd0};
      6:       w = {"HELP", 8'd0};
      7:       w = {"QUIT", 8'd0};
      8:       w = {"CAR", 16'd0};
      9:       w = {"CDR", 16'd0};
      10:      w = "ABOUT";
      11:      w = "PRINT";
      12:      w = "DEFUN";
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
    logic [8*KW_POS-1:0] w;
    w = kw_word(k);
    return w[(KW_POS - 1 - int'(p)) * 8 +: 8];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sexpr_token_scanner.sv
// ----------------------------------------------------------------------------
// sexpr_token_scanner
// Character-serial tokenizer for a Lisp-like stream with keyword matching.
// ----------------------------------------------------------------------------
// Results: each accepted item is held in the input register, goes through
//   the step logic and is written into the result queue when it advances.
// Throughput: one item per cycle while the 4-entry result queue has room for
//   two; the output side drains one result per cycle while out_ready is high,
//   so items that close a token and start another leave two results to drain.
// Reset: synchronous, clears the input valid flag, the scanner state (idle)
//   and the result queue pointers and level.
`default_nettype none

module sexpr_token_scanner (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sts_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sts_pkg::out_item_t  out_item
);

  logic                   in_valid_q;
  sts_pkg::in_item_t      in_q;
  sts_pkg::scan_state_t   state;
  sts_pkg::scan_state_t   state_next;
  sts_pkg::step_out_t     step_res;
  sts_pkg::fifo_status_t  fifo_status;
  logic                   advance;
  logic [1:0]             wr_count;

  assign advance  = in_valid_q && fifo_status.room2;
  assign in_ready = !in_valid_q || advance;
  assign wr_count = advance ? step_res.count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      state      <= sts_pkg::SCAN_RESET;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid;
      end
      if (advance) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
  end

  sts_step u_step (
    .state      (state),
    .item       (in_q),
    .state_next (state_next),
    .result     (step_res)
  );

  sts_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_count  (wr_count),
    .wr_item   (step_res.item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .status    (fifo_status)
  );

  // queue never goes past its depth
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_status.level <= sts_pkg::FIFO_CNT_W'(sts_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // an end mark always leaves the scanner idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.end_of_input |=> state.mode == sts_pkg::MODE_IDLE)
    else $error("scanner not idle after end mark");

  // sign and signed-word flags only live inside a word
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    state.mode == sts_pkg::MODE_IDLE |-> !state.neg && state.swf == 2'b00)
    else $error("stale sign state while idle");

  // magnitude saturates at 2^31
  a_acc_cap: assert property (@(posedge clk) disable iff (rst)
    state.acc <= sts_pkg::MAG_CAP)
    else $error("accumulator past saturation");

endmodule

`default_nettype wire

// File: hw/rtl/sts_step.sv
// ----------------------------------------------------------------------------
// sts_step
// Next-state and result logic for one character or end mark.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_step (
  input  sts_pkg::scan_state_t state,
  input  sts_pkg::in_item_t    item,
  output sts_pkg::scan_state_t state_next,
  output sts_pkg::step_out_t   result
);

  function automatic sts_pkg::scan_state_t word_char(input sts_pkg::scan_state_t s,
                                                    input logic [7:0] c);
    sts_pkg::scan_state_t          r;
    logic [7:0]                    u;
    logic [sts_pkg::WLEN_W-1:0]    p;
    logic [2:0]                    pi;
    r  = s;
    p  = s.wlen;
    u  = sts_pkg::upcase(c);
    pi = (p < sts_pkg::WLEN_W'(sts_pkg::KW_POS)) ? p[2:0] : 3'd0;
    if (p == '0) begin
      r.first = c;
      r.neg   = (c == sts_pkg::CH_MINUS);
      r.swf   = '0;
      r.acc   = '0;
      r.kwm   = '1;
    end else if (p == sts_pkg::WLEN_W'(1) &&
                 (s.first == sts_pkg::CH_PLUS || s.first == sts_pkg::CH_MINUS) &&
                 sts_pkg::is_digit(c)) begin
      r.swf[0] = 1'b1;
      r.acc    = sts_pkg::accumulate(s.acc, c);
    end else if (s.swf[0]) begin
      if (sts_pkg::is_digit(c)) begin
        r.acc = sts_pkg::accumulate(s.acc, c);
      end else begin
        r.swf[1] = 1'b1;
      end
    end
    for (int k = 0; k < sts_pkg::NKW; k++) begin
      if (sts_pkg::WLEN_W'(sts_pkg::kw_len(k)) <= p || sts_pkg::kw_char(k, pi) != u) begin
        r.kwm[k] = 1'b0;
      end
    end
    r.wlen = (p >= sts_pkg::WLEN_W'(sts_pkg::MAX_WORD - 1)) ?
             sts_pkg::WLEN_W'(sts_pkg::MAX_WORD) : p + sts_pkg::WLEN_W'(1);
    return r;
  endfunction

  logic [7:0]           c;
  logic                 close_valid;
  sts_pkg::out_item_t   close_item;
  logic                 kw_hit;
  logic [3:0]           kw_idx;
  logic [31:0]          pos_sat;
  logic [31:0]          signed_val;
  sts_pkg::scan_state_t idle_s;
  logic                 tok_valid;
  sts_pkg::out_item_t   tok_item;
  logic                 emit_close;
  logic                 done;

  assign c = item.char_code;

  // token closing, always taken from the state before this item
  always_comb begin
    pos_sat    = (state.acc > sts_pkg::POS_MAX) ? sts_pkg::POS_MAX : state.acc;
    signed_val = state.neg ? (32'd0 - state.acc) : pos_sat;
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = sts_pkg::NKW - 1; k >= 0; k--) begin
      if (state.kwm[k] && sts_pkg::WLEN_W'(sts_pkg::kw_len(k)) == state.wlen) begin
        kw_hit = 1'b1;
        kw_idx = 4'(k);
      end
    end
    close_valid      = 1'b1;
    close_item.last  = 1'b0;
    close_item.kind  = sts_pkg::KIND_NUMBER;
    close_item.value = pos_sat;
    unique case (state.mode)
      sts_pkg::MODE_IDLE: begin
        close_valid = 1'b0;
      end
      sts_pkg::MODE_NUM: begin
        close_item.kind  = sts_pkg::KIND_NUMBER;
        close_item.value = pos_sat;
      end
      sts_pkg::MODE_UNK: begin
        close_item.kind  = sts_pkg::KIND_UNKNOWN;
        close_item.value = 32'(state.wlen);
      end
      sts_pkg::MODE_WORD: begin
        if (state.wlen >= sts_pkg::WLEN_W'(sts_pkg::MAX_WORD)) begin
          close_item.kind  = sts_pkg::KIND_ERROR;
          close_item.value = sts_pkg::ERR_LONG;
        end else if (state.swf[0]) begin
          if (state.swf[1]) begin
            close_item.kind  = sts_pkg::KIND_ERROR;
            close_item.value = sts_pkg::ERR_SIGNED;
          end else begin
            close_item.kind  = sts_pkg::KIND_NUMBER;
            close_item.value = signed_val;
          end
        end else if (kw_hit) begin
          close_item.kind  = sts_pkg::KIND_KEYWORD;
          close_item.value = 32'(kw_idx);
        end else begin
          close_item.kind  = sts_pkg::KIND_VARIABLE;
          close_item.value = 32'(state.wlen);
        end
      end
    endcase
  end

  always_comb begin
    idle_s      = state;
    idle_s.mode = sts_pkg::MODE_IDLE;
    idle_s.acc  = '0;
    idle_s.neg  = 1'b0;
    idle_s.swf  = '0;
    idle_s.kwm  = '1;
    idle_s.wlen = '0;

    state_next     = state;
    tok_valid      = 1'b0;
    tok_item.kind  = sts_pkg::KIND_NAME;
    tok_item.value = {24'd0, c};
    tok_item.last  = 1'b0;
    emit_close     = 1'b0;
    done           = 1'b0;

    if (item.end_of_input) begin
      state_next    = idle_s;
      emit_close    = close_valid;
      tok_valid     = 1'b1;
      tok_item.kind = sts_pkg::KIND_END;
      tok_item.value = '0;
    end else begin
      unique case (state.mode)
        sts_pkg::MODE_IDLE: begin
        end
        sts_pkg::MODE_NUM: begin
          if (sts_pkg::is_digit(c)) begin
            state_next.acc = sts_pkg::accumulate(state.acc, c);
            done = 1'b1;
          end
        end
        sts_pkg::MODE_WORD: begin
          if (sts_pkg::is_word_char(c)) begin
            state_next     = word_char(state, c);
            tok_valid      = 1'b1;
            tok_item.value = {24'd0, sts_pkg::upcase(c)};
            done = 1'b1;
          end
        end
        sts_pkg::MODE_UNK: begin
          if (!sts_pkg::is_space(c) && c != sts_pkg::CH_LPAREN &&
              c != sts_pkg::CH_RPAREN) begin
            state_next.wlen = (state.wlen >= sts_pkg::WLEN_W'(sts_pkg::MAX_WORD - 1)) ?
                              sts_pkg::WLEN_W'(sts_pkg::MAX_WORD) :
                              state.wlen + sts_pkg::WLEN_W'(1);
            tok_valid = 1'b1;
            done = 1'b1;
          end
        end
      endcase

      // character ends the pending token and, unless it is white space, starts the next one
      if (!done) begin
        state_next = idle_s;
        emit_close = close_valid;
        priority if (sts_pkg::is_space(c)) begin
        end else if (sts_pkg::is_digit(c)) begin
          state_next.mode = sts_pkg::MODE_NUM;
          state_next.acc  = sts_pkg::accumulate(32'd0, c);
        end else if (c == sts_pkg::CH_LPAREN) begin
          tok_valid      = 1'b1;
          tok_item.kind  = sts_pkg::KIND_LPAREN;
          tok_item.value = '0;
        end else if (c == sts_pkg::CH_RPAREN) begin
          tok_valid      = 1'b1;
          tok_item.kind  = sts_pkg::KIND_RPAREN;
          tok_item.value = '0;
        end else if (sts_pkg::is_word_char(c)) begin
          state_next      = word_char(idle_s, c);
          state_next.mode = sts_pkg::MODE_WORD;
          tok_valid       = 1'b1;
          tok_item.value  = {24'd0, sts_pkg::upcase(c)};
        end else if (c == sts_pkg::CH_QUOTE) begin
          tok_valid      = 1'b1;
          tok_item.kind  = sts_pkg::KIND_QUOTE;
          tok_item.value = '0;
        end else begin
          state_next.mode = sts_pkg::MODE_UNK;
          state_next.wlen = sts_pkg::WLEN_W'(1);
          tok_valid       = 1'b1;
        end
      end
    end

    result.item[0] = tok_item;
    result.item[1] = tok_item;
    result.item[1].last = 1'b1;
    if (emit_close && tok_valid) begin
      result.count   = 2'd2;
      result.item[0] = close_item;
    end else if (emit_close) begin
      result.count   = 2'd1;
      result.item[0] = close_item;
    end else begin
      result.count   = tok_valid ? 2'd1 : 2'd0;
    end
    result.item[0].last = (result.count == 2'd1);
  end

endmodule

`default_nettype wire

// File: hw/rtl/sts_result_fifo.sv
// ----------------------------------------------------------------------------
// sts_result_fifo
// Small result queue: takes up to two items per cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sts_result_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [1:0]                      wr_count,
  input  sts_pkg::out_item_t [1:0]        wr_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output sts_pkg::out_item_t              out_item,
  output sts_pkg::fifo_status_t           status
);

  sts_pkg::out_item_t                mem [sts_pkg::FIFO_DEPTH];
  logic [sts_pkg::FIFO_PTR_W-1:0]    wptr;
  logic [sts_pkg::FIFO_PTR_W-1:0]    rptr;
  logic [sts_pkg::FIFO_CNT_W-1:0]    level;
  logic                              rd;

  assign out_valid    = (level != '0);
  assign rd           = out_valid && out_ready;
  assign out_item     = mem[rptr];
  assign status.level = level;
  assign status.room2 = (level <= sts_pkg::FIFO_CNT_W'(sts_pkg::FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + sts_pkg::FIFO_PTR_W'(wr_count);
      rptr  <= rptr + sts_pkg::FIFO_PTR_W'(rd);
      level <= level + sts_pkg::FIFO_CNT_W'(wr_count) - sts_pkg::FIFO_CNT_W'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wptr] <= wr_item[0];
    end
    if (wr_count == 2'd2) begin
      mem[wptr + sts_pkg::FIFO_PTR_W'(1)] <= wr_item[1];
    end
  end

endmodule

`default_nettype wire
